### sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define SULW_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sulw assertion failed");

// same on the block clock and reset
`define SULW_ASSERT_DEF(name, prop) \
  `SULW_ASSERT(name, clk_i, rst_ni, prop)

`endif

### sv/sulw_pkg.sv
package sulw_pkg;

  localparam int LEVEL_W        = 26;
  localparam int COUNT_W        = 7;
  localparam int CFG_IDX_W      = 2;
  localparam int MAX_LEVELS_DEF = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 2'd1;

  typedef logic [LEVEL_W-1:0] level_t;

  localparam level_t LOWER_RESET = '0;
  localparam level_t UPPER_RESET = '1;

  typedef struct packed {
    level_t supply_level;
    logic   final_item;
  } in_item_t;

  typedef struct packed {
    level_t             kept_level;
    logic [COUNT_W-1:0] kept_count;
    logic               is_empty;
    logic               overflow;
    logic               end_of_run;
  } out_item_t;

  typedef struct packed {
    logic   valid;
    level_t level;
  } slot_t;

endpackage

### sv/sulw_cell.sv
module sulw_cell
  import sulw_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  emit_i,
  input  slot_t in_i,
  input  slot_t nbr_i,
  output slot_t held_o,
  output slot_t pass_o,
  output logic  fill_o
);

  logic   held_valid_q, held_valid_d;
  level_t held_level_q, held_level_d;
  logic   pass_valid_q, pass_valid_d;
  level_t pass_level_q, pass_level_d;

  always_comb begin
    held_valid_d = held_valid_q;
    held_level_d = held_level_q;
    pass_valid_d = 1'b0;
    pass_level_d = in_i.level;
    fill_o       = 1'b0;
    if (emit_i) begin
      held_valid_d = nbr_i.valid;
      held_level_d = nbr_i.level;
    end else if (in_i.valid) begin
      if (!held_valid_q) begin
        held_valid_d = 1'b1;
        held_level_d = in_i.level;
        fill_o       = 1'b1;
      end else if (in_i.level == held_level_q) begin
        // duplicate, dropped here
        pass_valid_d = 1'b0;
      end else if (in_i.level < held_level_q) begin
        held_level_d = in_i.level;
        pass_valid_d = 1'b1;
        pass_level_d = held_level_q;
      end else begin
        pass_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      pass_valid_q <= 1'b0;
    end else begin
      held_valid_q <= held_valid_d;
      pass_valid_q <= pass_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_level_q <= held_level_d;
    pass_level_q <= pass_level_d;
  end

  assign held_o = '{valid: held_valid_q, level: held_level_q};
  assign pass_o = '{valid: pass_valid_q, level: pass_level_q};

endmodule

### sv/sorted_unique_level_window_unit.sv
// Collects a list of levels, one per accepted item (start high, busy low), at up to one
// item per cycle. Each level inside the configured bounds walks a chain of MAX_LEVELS
// insertion cells that keeps the distinct levels in ascending order; levels beyond
// MAX_LEVELS items are dropped and reported as overflow. After the final item busy stays
// high while the chain settles, then the kept levels leave one per cycle from the head
// of the chain, kept_count results in all (one empty result when none survives).
// Results are shown for a single cycle with result_valid_o and cannot be held off.
// Bounds are written through the configuration channel between lists; cfg_ready_o is
// low while a list is loading, settling or being emitted and while start is high.
module sorted_unique_level_window_unit
  import sulw_pkg::*;
#(
  parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             item_i,
  output logic                 result_valid_o,
  output out_item_t            result_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  level_t               cfg_data_i
);

  localparam int CNT_W = $clog2(MAX_LEVELS + 1);
  localparam int DRN_W = $clog2(MAX_LEVELS);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DRAIN = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] item_cnt_q, item_cnt_d;
  logic [CNT_W-1:0] kept_q, kept_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [DRN_W-1:0] drain_q, drain_d;
  logic             ovf_q, ovf_d;
  level_t           lower_q, upper_q;

  logic             accept, room, in_range, emit, last, fill_any;
  slot_t            link_s [MAX_LEVELS+1];
  slot_t            held_s [MAX_LEVELS];
  logic [MAX_LEVELS-1:0] fill_s;

  assign cfg_ready_o = !busy && (item_cnt_q == '0) && !start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= LOWER_RESET;
      upper_q <= UPPER_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_LOWER: lower_q <= cfg_data_i;
        CFG_UPPER: upper_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy     = state_q != ST_IDLE;
  assign accept   = start && !busy;
  assign room     = item_cnt_q < CNT_W'(MAX_LEVELS);
  assign in_range = (item_i.supply_level >= lower_q) && (item_i.supply_level <= upper_q);
  assign emit     = state_q == ST_EMIT;
  assign fill_any = |fill_s;
  assign last     = (kept_q == '0) || (CNT_W'(idx_q + 1'b1) == kept_q);

  assign link_s[0] = '{valid: accept && room && in_range, level: item_i.supply_level};

  for (genvar i = 0; i < MAX_LEVELS; i++) begin : g_cell
    slot_t nbr;
    if (i == MAX_LEVELS - 1) begin : g_tail
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = held_s[i+1];
    end
    sulw_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .emit_i (emit),
      .in_i   (link_s[i]),
      .nbr_i  (nbr),
      .held_o (held_s[i]),
      .pass_o (link_s[i+1]),
      .fill_o (fill_s[i])
    );
  end

  always_comb begin
    state_d    = state_q;
    item_cnt_d = item_cnt_q;
    kept_d     = kept_q + CNT_W'(fill_any);
    idx_d      = idx_q;
    drain_d    = drain_q;
    ovf_d      = ovf_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (room) begin
            item_cnt_d = item_cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (item_i.final_item) begin
            state_d = ST_DRAIN;
            drain_d = '0;
          end
        end
      end
      ST_DRAIN: begin
        drain_d = drain_q + 1'b1;
        if (drain_q == DRN_W'(MAX_LEVELS - 1)) begin
          state_d = ST_EMIT;
          idx_d   = '0;
        end
      end
      ST_EMIT: begin
        kept_d = kept_q;
        idx_d  = idx_q + 1'b1;
        if (last) begin
          state_d    = ST_IDLE;
          item_cnt_d = '0;
          kept_d     = '0;
          ovf_d      = 1'b0;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      item_cnt_q <= '0;
      kept_q     <= '0;
      idx_q      <= '0;
      drain_q    <= '0;
      ovf_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      item_cnt_q <= item_cnt_d;
      kept_q     <= kept_d;
      idx_q      <= idx_d;
      drain_q    <= drain_d;
      ovf_q      <= ovf_d;
    end
  end

  assign result_valid_o      = emit;
  assign result_o.kept_level = (kept_q == '0) ? '0 : held_s[0].level;
  assign result_o.kept_count = COUNT_W'(kept_q);
  assign result_o.is_empty   = kept_q == '0;
  assign result_o.overflow   = ovf_q;
  assign result_o.end_of_run = last;

endmodule

### sv/sulw_checker.sv
`include "assert_macros.svh"

module sulw_checker
  import sulw_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      busy,
  input logic      result_valid_o,
  input out_item_t result_o
);

  logic               res_fire, res_last, res_empty;
  level_t             res_level;
  logic [COUNT_W-1:0] res_count;

  assign res_fire  = result_valid_o;
  assign res_last  = result_o.end_of_run;
  assign res_empty = result_o.is_empty;
  assign res_level = result_o.kept_level;
  assign res_count = result_o.kept_count;

  // results only while the block is busy
  `SULW_ASSERT_DEF(a_result_busy, res_fire |-> busy)

  // an empty outcome is a single closing result with no count
  `SULW_ASSERT_DEF(a_empty_alone, (res_fire && res_empty) |-> (res_last && (res_count == '0)))

  // a run of results has no gaps
  `SULW_ASSERT_DEF(a_run_contig, (res_fire && !res_last) |=> res_fire)

  // kept levels leave strictly ascending
  `SULW_ASSERT_DEF(a_run_ascend, (res_fire && !res_last) |=> ($past(res_level) < res_level))

  // the last result frees the block
  `SULW_ASSERT_DEF(a_end_idle, (res_fire && res_last) |=> (!res_fire && !busy))

endmodule

bind sorted_unique_level_window_unit sulw_checker u_sulw_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
